### rtl/tlc_pkg.sv
// Package for the traffic light controller: light and event codes,
// register indexes, reset values and the structs shared between modules.
// No dependencies.
package tlc_pkg;

    localparam int TIME_BITS_DEF = 12;
    localparam int CFG_W         = 12;
    localparam int HOLD_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int BUZZ_W        = 4;
    localparam int BLINK_W       = 3;

    localparam logic [CFG_W-1:0]  GREEN_TICKS_RST     = 12'd300;
    localparam logic [CFG_W-1:0]  YELLOW_TICKS_RST    = 12'd50;
    localparam logic [CFG_W-1:0]  RED_TICKS_RST       = 12'd50;
    localparam logic [CFG_W-1:0]  WALK_TICKS_RST      = 12'd200;
    localparam logic [CFG_W-1:0]  MIN_GREEN_TICKS_RST = 12'd100;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST      = 8'd20;

    localparam logic [HOLD_W-1:0]  HOLD_MAX      = 8'd255;
    localparam logic [BUZZ_W-1:0]  BUZZ_LAST     = 4'd9;
    localparam logic [BUZZ_W-1:0]  BUZZ_ON_TICKS = 4'd5;
    localparam logic [BLINK_W-1:0] BLINK_LAST    = 3'd4;
    localparam logic [BLINK_W-1:0] BLINK_ON_TICKS = 3'd3;

    typedef enum logic [2:0] {
        L_GREEN  = 3'd0,
        L_YELLOW = 3'd1,
        L_RED    = 3'd2,
        L_WALK   = 3'd3,
        L_EMERG  = 3'd4
    } t_light;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_TIMEOUT   = 3'd1,
        EV_PED       = 3'd2,
        EV_EMERG     = 3'd3,
        EV_EMERG_END = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_TICKS     = 3'd0,
        CFG_YELLOW_TICKS    = 3'd1,
        CFG_RED_TICKS       = 3'd2,
        CFG_WALK_TICKS      = 3'd3,
        CFG_MIN_GREEN_TICKS = 3'd4,
        CFG_HOLD_LIMIT      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  green_ticks;
        logic [CFG_W-1:0]  yellow_ticks;
        logic [CFG_W-1:0]  red_ticks;
        logic [CFG_W-1:0]  walk_ticks;
        logic [CFG_W-1:0]  min_green_ticks;
        logic [HOLD_W-1:0] hold_limit;
    } t_cfg;

    typedef struct packed {
        t_light             light;
        logic               ped_waiting;
        logic               emergency_active;
        logic [HOLD_W-1:0]  hold_count;
        logic [BUZZ_W-1:0]  buzz_phase;
        logic [BLINK_W-1:0] blink_phase;
    } t_state;

    typedef struct packed {
        logic [2:0] light_state;
        logic [2:0] event_taken;
        logic       car_green;
        logic       car_yellow;
        logic       car_red;
        logic       walk_green;
        logic       walk_red;
        logic       buzzer_on;
    } t_result;

endpackage

### rtl/tlc_if.sv
// Channel interfaces of the traffic light controller: tick input, result
// output and configuration write. Depends on tlc_pkg.
interface tlc_tick_if;
    logic valid;
    logic ready;
    logic ped_press;
    logic emergency_held;

    modport source (output valid, output ped_press, output emergency_held, input ready);
    modport sink   (input valid, input ped_press, input emergency_held, output ready);
endinterface

interface tlc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] light_state;
    logic [2:0] event_taken;
    logic       car_green;
    logic       car_yellow;
    logic       car_red;
    logic       walk_green;
    logic       walk_red;
    logic       buzzer_on;

    modport source (
        output valid, output light_state, output event_taken, output car_green,
        output car_yellow, output car_red, output walk_green, output walk_red,
        output buzzer_on, input ready
    );
    modport sink (
        input valid, input light_state, input event_taken, input car_green,
        input car_yellow, input car_red, input walk_green, input walk_red,
        input buzzer_on, output ready
    );
endinterface

interface tlc_cfg_if;
    import tlc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tlc_step.sv
// Per-tick update of the traffic light controller: event selection,
// light transitions and lamp decode. Depends on tlc_pkg.
module tlc_step #(
    parameter int TIME_BITS = tlc_pkg::TIME_BITS_DEF
) (
    input  tlc_pkg::t_state        i_state,
    input  logic [TIME_BITS-1:0]   i_elapsed,
    input  tlc_pkg::t_cfg          i_cfg,
    input  logic                   i_ped_press,
    input  logic                   i_emergency_held,
    output tlc_pkg::t_state        o_state,
    output logic [TIME_BITS-1:0]   o_elapsed,
    output tlc_pkg::t_result       o_result
);
    import tlc_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic [HOLD_W-1:0]    hold_inc;
    t_event               ev;
    t_state               nxt;

    always_comb begin
        elapsed_inc = (i_elapsed == TIME_MAX) ? i_elapsed : i_elapsed + 1'b1;
        elapsed_cmp = CMP_W'(elapsed_inc);
        hold_inc    = (i_state.hold_count == HOLD_MAX) ? i_state.hold_count
                                                       : i_state.hold_count + 1'b1;
        nxt = i_state;
        ev  = EV_NONE;
        nxt.buzz_phase  = (i_state.buzz_phase >= BUZZ_LAST) ? '0 : i_state.buzz_phase + 1'b1;
        nxt.blink_phase = (i_state.blink_phase >= BLINK_LAST) ? '0
                                                              : i_state.blink_phase + 1'b1;

        if (i_emergency_held) begin
            if (hold_inc > i_cfg.hold_limit) begin
                nxt.emergency_active = 1'b1;
                nxt.hold_count       = '0;
                ev                   = EV_EMERG;
            end else begin
                nxt.hold_count = hold_inc;
            end
        end else begin
            nxt.hold_count = '0;
            if (i_state.emergency_active) begin
                nxt.emergency_active = 1'b0;
                ev                   = EV_EMERG_END;
            end
        end

        if (i_ped_press) begin
            nxt.ped_waiting = 1'b1;
            if (ev == EV_NONE) begin
                ev = EV_PED;
            end
        end

        if (ev == EV_NONE) begin
            case (i_state.light)
                L_GREEN: begin
                    if (elapsed_cmp >= CMP_W'(i_cfg.green_ticks)) begin
                        ev = EV_TIMEOUT;
                    end else if (nxt.ped_waiting &&
                                 elapsed_cmp >= CMP_W'(i_cfg.min_green_ticks)) begin
                        ev = EV_PED;
                    end
                end
                L_YELLOW: if (elapsed_cmp >= CMP_W'(i_cfg.yellow_ticks)) ev = EV_TIMEOUT;
                L_RED:    if (elapsed_cmp >= CMP_W'(i_cfg.red_ticks))    ev = EV_TIMEOUT;
                L_WALK:   if (elapsed_cmp >= CMP_W'(i_cfg.walk_ticks))   ev = EV_TIMEOUT;
                default:  ev = EV_NONE;
            endcase
        end

        if (ev != EV_NONE) begin
            case (i_state.light)
                L_GREEN: begin
                    if (ev == EV_TIMEOUT || ev == EV_PED) nxt.light = L_YELLOW;
                    else if (ev == EV_EMERG)              nxt.light = L_EMERG;
                end
                L_YELLOW: begin
                    if (ev == EV_TIMEOUT) begin
                        if (nxt.ped_waiting) begin
                            nxt.ped_waiting = 1'b0;
                            nxt.light       = L_WALK;
                        end else begin
                            nxt.light = L_RED;
                        end
                    end else if (ev == EV_EMERG) begin
                        nxt.light = L_EMERG;
                    end
                end
                L_RED: begin
                    if (ev == EV_TIMEOUT)     nxt.light = L_GREEN;
                    else if (ev == EV_EMERG)  nxt.light = L_EMERG;
                end
                L_WALK: begin
                    if (ev == EV_TIMEOUT)     nxt.light = L_RED;
                    else if (ev == EV_EMERG)  nxt.light = L_EMERG;
                end
                L_EMERG: begin
                    if (ev == EV_EMERG_END) begin
                        nxt.ped_waiting = 1'b0;
                        nxt.buzz_phase  = '0;
                        nxt.blink_phase = '0;
                        nxt.light       = L_RED;
                    end
                end
                default: begin
                    nxt.ped_waiting = 1'b0;
                    nxt.light       = L_RED;
                end
            endcase
        end

        o_elapsed = (nxt.light != i_state.light) ? '0 : elapsed_inc;
        o_state   = nxt;
    end

    always_comb begin
        o_result             = '0;
        o_result.light_state = nxt.light;
        o_result.event_taken = ev;
        case (nxt.light)
            L_GREEN: begin
                o_result.car_green = 1'b1;
                o_result.walk_red  = 1'b1;
            end
            L_YELLOW: begin
                o_result.car_yellow = 1'b1;
                o_result.walk_red   = 1'b1;
            end
            L_RED: begin
                o_result.car_red  = 1'b1;
                o_result.walk_red = 1'b1;
            end
            L_WALK: begin
                o_result.car_red    = 1'b1;
                o_result.walk_green = 1'b1;
                o_result.buzzer_on  = nxt.buzz_phase < BUZZ_ON_TICKS;
            end
            L_EMERG: begin
                o_result.car_red  = nxt.blink_phase < BLINK_ON_TICKS;
                o_result.walk_red = nxt.blink_phase < BLINK_ON_TICKS;
            end
            default: o_result.light_state = nxt.light;
        endcase
    end

endmodule

### rtl/traffic_light_controller.sv
// Traffic light controller with pedestrian request and emergency mode.
// Top level: configuration registers, state registers and result register.
// Depends on tlc_pkg, tlc_if and tlc_step.
//
//   channel    direction  payload                                   accepted when
//   i_tick     in         ped_press, emergency_held                 valid && ready
//   o_result   out        light_state, event_taken, lamps, buzzer   valid && ready
//   i_cfg      in         index, data                               valid && ready
//
// For each tick item the state update is one pass of logic from the
// state registers into the state and result registers.
// A tick is accepted in every cycle while the result register is empty or being read.
// A stalled result holds; i_cfg is always ready. Reset is synchronous and active low
// and restores the register defaults and the vehicle red state.
module traffic_light_controller #(
    parameter int TIME_BITS = tlc_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlc_tick_if.sink    i_tick,
    tlc_result_if.source o_result,
    tlc_cfg_if.sink     i_cfg
);
    import tlc_pkg::*;

    t_cfg                 r_cfg;
    t_state               r_state;
    logic [TIME_BITS-1:0] r_elapsed;
    t_result              r_res;
    logic                 r_res_valid;

    t_state               n_state;
    logic [TIME_BITS-1:0] n_elapsed;
    t_result              n_res;
    logic                 tick_accept;

    assign i_cfg.ready   = 1'b1;
    assign i_tick.ready  = !r_res_valid || o_result.ready;
    assign tick_accept   = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.green_ticks     <= GREEN_TICKS_RST;
            r_cfg.yellow_ticks    <= YELLOW_TICKS_RST;
            r_cfg.red_ticks       <= RED_TICKS_RST;
            r_cfg.walk_ticks      <= WALK_TICKS_RST;
            r_cfg.min_green_ticks <= MIN_GREEN_TICKS_RST;
            r_cfg.hold_limit      <= HOLD_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GREEN_TICKS:     r_cfg.green_ticks     <= i_cfg.data;
                CFG_YELLOW_TICKS:    r_cfg.yellow_ticks    <= i_cfg.data;
                CFG_RED_TICKS:       r_cfg.red_ticks       <= i_cfg.data;
                CFG_WALK_TICKS:      r_cfg.walk_ticks      <= i_cfg.data;
                CFG_MIN_GREEN_TICKS: r_cfg.min_green_ticks <= i_cfg.data;
                CFG_HOLD_LIMIT:      r_cfg.hold_limit      <= i_cfg.data[HOLD_W-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    tlc_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .i_state         (r_state),
        .i_elapsed       (r_elapsed),
        .i_cfg           (r_cfg),
        .i_ped_press     (i_tick.ped_press),
        .i_emergency_held(i_tick.emergency_held),
        .o_state         (n_state),
        .o_elapsed       (n_elapsed),
        .o_result        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.light            <= L_RED;
            r_state.ped_waiting      <= 1'b0;
            r_state.emergency_active <= 1'b0;
            r_state.hold_count       <= '0;
            r_state.buzz_phase       <= '0;
            r_state.blink_phase      <= '0;
            r_elapsed                <= '0;
            r_res_valid              <= 1'b0;
        end else begin
            if (tick_accept) begin
                r_state     <= n_state;
                r_elapsed   <= n_elapsed;
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid       = r_res_valid;
    assign o_result.light_state = r_res.light_state;
    assign o_result.event_taken = r_res.event_taken;
    assign o_result.car_green   = r_res.car_green;
    assign o_result.car_yellow  = r_res.car_yellow;
    assign o_result.car_red     = r_res.car_red;
    assign o_result.walk_green  = r_res.walk_green;
    assign o_result.walk_red    = r_res.walk_red;
    assign o_result.buzzer_on   = r_res.buzzer_on;

`ifndef NO_ASSERTIONS
    a_emerg_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.light == L_EMERG) == r_state.emergency_active)
        else $error("emergency flag disagrees with the light state");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.buzz_phase <= BUZZ_LAST && r_state.blink_phase <= BLINK_LAST)
        else $error("buzzer or blink phase out of range");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> r_res_valid)
        else $error("accepted tick item produced no result item");

    a_elapsed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept && n_state.light != r_state.light |=> r_elapsed == '0)
        else $error("elapsed time not cleared on a light change");
`endif

endmodule
